### hdl/assert_macros.svh
// Assertion macros shared by the swept sphere collision block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/ssbh_pkg.sv
// Shared types, codes and constants of the swept sphere box hit block.
// No dependencies; the RTL modules and the testbench import it.
package ssbh_pkg;

   // Box store geometry.
   localparam int MAX_BOXES = 16;
   localparam int BOX_IDX_W = $clog2(MAX_BOXES);
   localparam int BOX_CNT_W = $clog2(MAX_BOXES + 1);

   // Divider geometry: numerator is a 35-bit offset scaled by 2^16.
   localparam int DIV_NUM_W = 51;
   localparam int DIV_DEN_W = 32;
   localparam int DIV_Q_W   = 19;
   localparam int T_W       = DIV_Q_W + 2;

   // Clamped quotients; any time beyond these lies far outside [0, 1].
   localparam logic signed [T_W-1:0] T_POS_SAT = T_W'(1 << DIV_Q_W);
   localparam logic signed [T_W-1:0] T_NEG_SAT = -T_W'((1 << DIV_Q_W) + 1);
   localparam logic [16:0]           T_ONE     = 17'd65536;

   localparam logic [15:0] TIME_STEP_RESET = 16'd1092;

   // Item opcodes.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Control register indexes.
   localparam logic [1:0] CSR_TIME_STEP = 2'd0;
   localparam logic [1:0] CSR_BOX_COUNT = 2'd1;
   localparam logic [1:0] CSR_GROUND_EN = 2'd2;

   // Normal axis codes.
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // Multiplier operand selection.
   typedef logic [1:0] mul_op_type;
   localparam mul_op_type MUL_DISP  = 2'd0;
   localparam mul_op_type MUL_SQ    = 2'd1;
   localparam mul_op_type MUL_RAD   = 2'd2;
   localparam mul_op_type MUL_ALONG = 2'd3;

   // Use of the registered product.
   typedef logic [2:0] wb_op_type;
   localparam wb_op_type WB_NONE  = 3'd0;
   localparam wb_op_type WB_DISP  = 3'd1;
   localparam wb_op_type WB_SQ    = 3'd2;
   localparam wb_op_type WB_RAD   = 3'd3;
   localparam wb_op_type WB_ALONG = 3'd4;

   // Divider operand selection.
   typedef logic [1:0] div_sel_type;
   localparam div_sel_type DIV_GND = 2'd0;
   localparam div_sel_type DIV_LO  = 2'd1;
   localparam div_sel_type DIV_HI  = 2'd2;

   typedef struct packed {
      logic               op;
      logic [3:0]         slot;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [30:0]        half_x;
      logic [30:0]        half_y;
      logic [30:0]        half_z;
      logic [30:0]        radius;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [16:0]        hit_time;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [1:0]         normal_axis;
      logic               normal_negative;
   } rsp_type;

   typedef struct packed {
      logic [2:0][31:0] c;
      logic [2:0][30:0] h;
   } box_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic                 load_box;
      logic                 capture;
      logic [1:0]           axis;
      logic [BOX_IDX_W-1:0] box_idx;
      mul_op_type           mul_op;
      wb_op_type            wb_op;
      logic                 div_start;
      div_sel_type          div_sel;
      logic                 div_gnd;
      logic                 div_t1;
      logic                 div_slab;
      logic                 slab_zero;
      logic                 box_init;
      logic                 tuse_tmin;
      logic                 gnd_commit;
      logic                 box_commit;
      logic                 publish;
   } cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic far;
      logic ground_ok;
      logic d_zero;
      logic miss;
      logic better;
      logic div_done;
   } sts_type;

endpackage

### hdl/ssbh_if.sv
// Valid/ready channel interfaces for query beats and result beats.
// No dependencies.
interface ssbh_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic [3:0]         slot;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic [30:0]        half_x;
   logic [30:0]        half_y;
   logic [30:0]        half_z;
   logic [30:0]        radius;

   modport source (output valid, op, slot, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                   half_x, half_y, half_z, radius, input ready);
   modport sink (input valid, op, slot, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                 half_x, half_y, half_z, radius, output ready);
endinterface

interface ssbh_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic [16:0]        hit_time;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   logic [1:0]         normal_axis;
   logic               normal_negative;

   modport source (output valid, hit, hit_time, point_x, point_y, point_z, normal_axis,
                   normal_negative, input ready);
   modport sink (input valid, hit, hit_time, point_x, point_y, point_z, normal_axis,
                 normal_negative, output ready);
endinterface

### hdl/ssbh_div.sv
// Restoring divider with floor rounding and a clamped 19-bit quotient.
// Depends on ssbh_pkg.
module ssbh_div import ssbh_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [DIV_NUM_W-1:0] num,
   input  logic signed [DIV_DEN_W-1:0] den,
   output logic                        done,
   output logic signed [T_W-1:0]       quot
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [4:0]           cnt_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_Q_W-1:0]   low_ff;
   logic [DIV_DEN_W-1:0] dm_ff;
   logic                 neg_ff;
   logic                 ovf_ff;

   logic [DIV_NUM_W-1:0] nm;
   logic [DIV_DEN_W-1:0] dm;
   logic [DIV_DEN_W:0]   shifted;
   logic                 ge;
   logic [T_W-1:0]       qmag;

   // Operand magnitudes; the partial remainder starts from the upper bits.
   assign nm      = num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : num;
   assign dm      = den[DIV_DEN_W-1] ? DIV_DEN_W'(-den) : den;
   assign shifted = {rem_ff, low_ff[DIV_Q_W-1]};
   assign ge      = shifted >= {1'b0, dm_ff};

   // Control flags.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
      end else if (busy_ff && cnt_ff == 5'd1) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // One quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= nm[DIV_NUM_W-1:DIV_Q_W];
         low_ff <= nm[DIV_Q_W-1:0];
         dm_ff  <= dm;
         neg_ff <= num[DIV_NUM_W-1] ^ den[DIV_DEN_W-1];
         ovf_ff <= nm[DIV_NUM_W-1:DIV_Q_W] >= dm;
         cnt_ff <= 5'(DIV_Q_W);
      end else if (busy_ff) begin
         rem_ff <= ge ? DIV_DEN_W'(shifted - {1'b0, dm_ff}) : shifted[DIV_DEN_W-1:0];
         low_ff <= {low_ff[DIV_Q_W-2:0], ge};
         cnt_ff <= cnt_ff - 5'd1;
      end
   end

   // Floor toward minus infinity, clamped when the quotient overflows.
   assign qmag = {2'b00, low_ff};
   always_comb begin
      if (ovf_ff) begin
         quot = neg_ff ? T_NEG_SAT : T_POS_SAT;
      end else if (neg_ff) begin
         quot = -$signed(qmag + T_W'(rem_ff != '0));
      end else begin
         quot = $signed(qmag);
      end
   end

   assign done = done_ff;

endmodule

### hdl/ssbh_dp.sv
// Datapath: box store, shared multiplier, divider, slab and result registers.
// Depends on ssbh_pkg and ssbh_div.
module ssbh_dp import ssbh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  req_type     req,
   input  logic [15:0] time_step,
   output rsp_type     rsp
);

   localparam logic signed [33:0] SAT_HI = 34'sd2147483647;
   localparam logic signed [33:0] SAT_LO = -34'sd2147483648;

   logic signed [31:0] p_ff [3];
   logic signed [31:0] vel_ff [3];
   logic signed [31:0] d_ff [3];
   logic signed [33:0] q_ff [3];
   logic [31:0]        pt_ff [3];
   logic [30:0]        r_ff;
   logic [63:0]        acc_ff;
   logic [61:0]        lim_ff;
   logic signed [65:0] mul_ff;
   logic [16:0]        tuse_ff;
   logic [16:0]        best_ff;
   logic [1:0]         axis_ff;
   logic               neg_ff;
   logic               found_ff;
   logic               miss_ff;
   logic signed [T_W-1:0] tmin_ff, tmax_ff, t1_ff;
   box_type            box_mem [MAX_BOXES];
   box_type            box_rd_ff;
   box_type            new_box;
   rsp_type            rsp_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [31:0] d_ax, p_ax;
   logic signed [33:0] along_sum, lo34, hi34;
   logic signed [34:0] p35, lo_rel, hi_rel;
   logic signed [32:0] gnd_num, abs_num, abs_d1;
   logic               gnd_nonneg;
   logic signed [DIV_NUM_W-1:0] div_num;
   logic signed [DIV_DEN_W-1:0] div_den;
   logic signed [T_W-1:0]       div_q;
   logic                        div_done;
   logic signed [T_W-1:0] t_lo, t_hi, nmin, nmax;
   logic signed [34:0] dq [3];
   logic [34:0]        adq [3];
   logic [1:0]         n_axis;
   logic               n_neg;

   function automatic logic [31:0] sat32(input logic signed [33:0] v);
      logic [31:0] res;
      if (v > SAT_HI) begin
         res = 32'h7FFF_FFFF;
      end else if (v < SAT_LO) begin
         res = 32'h8000_0000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

   assign d_ax = d_ff[cmd.axis];
   assign p_ax = p_ff[cmd.axis];

   // Shared multiplier operands.
   always_comb begin
      case (cmd.mul_op)
         MUL_DISP: begin
            mul_a = {vel_ff[cmd.axis][31], vel_ff[cmd.axis]};
            mul_b = {17'b0, time_step};
         end
         MUL_SQ: begin
            mul_a = {d_ax[31], d_ax};
            mul_b = {d_ax[31], d_ax};
         end
         MUL_RAD: begin
            mul_a = {2'b00, r_ff};
            mul_b = {2'b00, r_ff};
         end
         MUL_ALONG: begin
            mul_a = {16'b0, tuse_ff};
            mul_b = {d_ax[31], d_ax};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Centre at the chosen time: p + floor(t * d / 2^16).
   assign along_sum = {{2{p_ax[31]}}, p_ax} + {mul_ff[48], mul_ff[48:16]};

   // Slab bounds of the box grown by the radius, relative to the start.
   assign lo34   = {{2{box_rd_ff.c[cmd.axis][31]}}, box_rd_ff.c[cmd.axis]}
                   - {3'b0, box_rd_ff.h[cmd.axis]} - {3'b0, r_ff};
   assign hi34   = {{2{box_rd_ff.c[cmd.axis][31]}}, box_rd_ff.c[cmd.axis]}
                   + {3'b0, box_rd_ff.h[cmd.axis]} + {3'b0, r_ff};
   assign p35    = {{3{p_ax[31]}}, p_ax};
   assign lo_rel = {lo34[33], lo34} - p35;
   assign hi_rel = {hi34[33], hi34} - p35;

   // Ground plane: contact only when -p.y / d.y lies in [0, 1].
   assign gnd_num    = -{p_ff[1][31], p_ff[1]};
   assign abs_num    = gnd_num[32] ? -gnd_num : gnd_num;
   assign abs_d1     = d_ff[1][31] ? -{d_ff[1][31], d_ff[1]} : {1'b0, d_ff[1]};
   assign gnd_nonneg = (gnd_num == '0)
                       || ((!gnd_num[32] && gnd_num != '0) == (!d_ff[1][31] && d_ff[1] != '0));

   // Divider operands.
   always_comb begin
      case (cmd.div_sel)
         DIV_GND: begin
            div_num = {{2{gnd_num[32]}}, gnd_num, 16'b0};
            div_den = d_ff[1];
         end
         DIV_LO: begin
            div_num = {lo_rel, 16'b0};
            div_den = d_ax;
         end
         DIV_HI: begin
            div_num = {hi_rel, 16'b0};
            div_den = d_ax;
         end
         default: begin
            div_num = '0;
            div_den = d_ax;
         end
      endcase
   end

   ssbh_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_q)
   );

   // Interval update from the two slab crossings.
   assign t_lo = (t1_ff > div_q) ? div_q : t1_ff;
   assign t_hi = (t1_ff > div_q) ? t1_ff : div_q;
   assign nmin = (t_lo > tmin_ff) ? t_lo : tmin_ff;
   assign nmax = (t_hi < tmax_ff) ? t_hi : tmax_ff;

   // Contact normal: axis of largest offset from the box centre.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         dq[a]  = {q_ff[a][33], q_ff[a]} - {{3{box_rd_ff.c[a][31]}}, box_rd_ff.c[a]};
         adq[a] = dq[a][34] ? 35'(-dq[a]) : dq[a];
      end
      if (adq[0] >= adq[1] && adq[0] >= adq[2]) begin
         n_axis = AXIS_X;
         n_neg  = dq[0][34] || dq[0] == '0;
      end else if (adq[1] >= adq[2]) begin
         n_axis = AXIS_Y;
         n_neg  = dq[1][34] || dq[1] == '0;
      end else begin
         n_axis = AXIS_Z;
         n_neg  = dq[2][34] || dq[2] == '0;
      end
   end

   // Status back to the sequencer.
   assign sts.far       = acc_ff > {2'b00, lim_ff};
   assign sts.ground_ok = (d_ff[1] != '0) && gnd_nonneg && (abs_num <= abs_d1);
   assign sts.d_zero    = d_ax == '0;
   assign sts.miss      = miss_ff;
   assign sts.better    = !miss_ff && (!found_ff || tmin_ff < $signed({4'b0, best_ff}));
   assign sts.div_done  = div_done;

   assign new_box.c = {req.pos_z, req.pos_y, req.pos_x};
   assign new_box.h = {req.half_z, req.half_y, req.half_x};

   // Box store, written by load beats and read at the box under test.
   always_ff @(posedge clock) begin
      box_rd_ff <= box_mem[cmd.box_idx];
      if (cmd.load_box && ({1'b0, req.slot} < 5'(MAX_BOXES))) begin
         box_mem[req.slot[BOX_IDX_W-1:0]] <= new_box;
      end
   end

   // Found flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.capture) begin
         found_ff <= 1'b0;
      end else if (cmd.gnd_commit || cmd.box_commit) begin
         found_ff <= 1'b1;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
      if (cmd.capture) begin
         p_ff[0]   <= req.pos_x;
         p_ff[1]   <= req.pos_y;
         p_ff[2]   <= req.pos_z;
         vel_ff[0] <= req.vel_x;
         vel_ff[1] <= req.vel_y;
         vel_ff[2] <= req.vel_z;
         r_ff      <= req.radius;
         acc_ff    <= '0;
      end
      case (cmd.wb_op)
         WB_DISP:  d_ff[cmd.axis] <= mul_ff[47:16];
         WB_SQ:    acc_ff <= acc_ff + mul_ff[63:0];
         WB_RAD:   lim_ff <= mul_ff[63:2];
         WB_ALONG: q_ff[cmd.axis] <= along_sum;
         default: ;
      endcase
      if (cmd.div_gnd) begin
         tuse_ff <= div_q[16:0];
      end
      if (cmd.tuse_tmin) begin
         tuse_ff <= tmin_ff[16:0];
      end
      if (cmd.div_t1) begin
         t1_ff <= div_q;
      end
      if (cmd.box_init) begin
         tmin_ff <= '0;
         tmax_ff <= $signed({4'b0, T_ONE});
         miss_ff <= 1'b0;
      end
      if (cmd.slab_zero) begin
         miss_ff <= miss_ff || (p35 < lo_rel + p35) || (p35 > hi_rel + p35);
      end
      if (cmd.div_slab) begin
         tmin_ff <= nmin;
         tmax_ff <= nmax;
         miss_ff <= nmin > nmax;
      end
      if (cmd.gnd_commit) begin
         best_ff  <= tuse_ff;
         pt_ff[0] <= sat32(q_ff[0]);
         pt_ff[1] <= {1'b0, r_ff};
         pt_ff[2] <= sat32(q_ff[2]);
         axis_ff  <= AXIS_Y;
         neg_ff   <= !d_ff[1][31] && d_ff[1] != '0;
      end
      if (cmd.box_commit) begin
         best_ff  <= tuse_ff;
         pt_ff[0] <= sat32(q_ff[0]);
         pt_ff[1] <= sat32(q_ff[1]);
         pt_ff[2] <= sat32(q_ff[2]);
         axis_ff  <= n_axis;
         neg_ff   <= n_neg;
      end
      if (cmd.publish) begin
         rsp_ff.hit             <= found_ff;
         rsp_ff.hit_time        <= found_ff ? best_ff : '0;
         rsp_ff.point_x         <= found_ff ? pt_ff[0] : '0;
         rsp_ff.point_y         <= found_ff ? pt_ff[1] : '0;
         rsp_ff.point_z         <= found_ff ? pt_ff[2] : '0;
         rsp_ff.normal_axis     <= found_ff ? axis_ff : AXIS_X;
         rsp_ff.normal_negative <= found_ff && neg_ff;
      end
   end

   assign rsp = rsp_ff;

endmodule

### hdl/ssbh_ctrl.sv
// Sequencer: walks a query through motion, ground and box tests.
// Depends on ssbh_pkg.
module ssbh_ctrl import ssbh_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_op,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [BOX_CNT_W-1:0] box_count,
   input  logic                 ground_en,
   output cmd_type              cmd,
   input  sts_type              sts
);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_DISP_M   = 5'd1;
   localparam logic [4:0] S_DISP_W   = 5'd2;
   localparam logic [4:0] S_SQ_M     = 5'd3;
   localparam logic [4:0] S_SQ_W     = 5'd4;
   localparam logic [4:0] S_RAD_M    = 5'd5;
   localparam logic [4:0] S_RAD_W    = 5'd6;
   localparam logic [4:0] S_CHK      = 5'd7;
   localparam logic [4:0] S_G_DIV    = 5'd8;
   localparam logic [4:0] S_G_WAIT   = 5'd9;
   localparam logic [4:0] S_ALONG_M  = 5'd10;
   localparam logic [4:0] S_ALONG_W  = 5'd11;
   localparam logic [4:0] S_G_COMMIT = 5'd12;
   localparam logic [4:0] S_BOX_TEST = 5'd13;
   localparam logic [4:0] S_B_READ   = 5'd14;
   localparam logic [4:0] S_B_AXIS   = 5'd15;
   localparam logic [4:0] S_B_W1     = 5'd16;
   localparam logic [4:0] S_B_W2     = 5'd17;
   localparam logic [4:0] S_B_NEXT   = 5'd18;
   localparam logic [4:0] S_B_CHECK  = 5'd19;
   localparam logic [4:0] S_B_COMMIT = 5'd20;
   localparam logic [4:0] S_B_INC    = 5'd21;
   localparam logic [4:0] S_FINISH   = 5'd22;

   localparam logic PASS_GROUND = 1'b0;
   localparam logic PASS_BOX    = 1'b1;

   logic [4:0]           state_ff, state_in;
   logic [1:0]           ax_ff, ax_in;
   logic [BOX_CNT_W-1:0] bi_ff, bi_in;
   logic                 which_ff, which_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BOX_CNT_W-1:0] nb;

   // Box count saturates at the store depth.
   assign nb = (box_count > BOX_CNT_W'(MAX_BOXES)) ? BOX_CNT_W'(MAX_BOXES) : box_count;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      ax_in        = ax_ff;
      bi_in        = bi_ff;
      which_in     = which_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.axis     = ax_ff;
      cmd.box_idx  = bi_ff[BOX_IDX_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_LOAD) begin
                  cmd.load_box = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  ax_in       = AXIS_X;
                  state_in    = S_DISP_M;
               end
            end
         end
         S_DISP_M: begin
            cmd.mul_op = MUL_DISP;
            state_in   = S_DISP_W;
         end
         S_DISP_W: begin
            cmd.wb_op = WB_DISP;
            if (ax_ff == AXIS_Z) begin
               ax_in    = AXIS_X;
               state_in = S_SQ_M;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = S_DISP_M;
            end
         end
         S_SQ_M: begin
            cmd.mul_op = MUL_SQ;
            state_in   = S_SQ_W;
         end
         S_SQ_W: begin
            cmd.wb_op = WB_SQ;
            if (ax_ff == AXIS_Z) begin
               ax_in    = AXIS_X;
               state_in = S_RAD_M;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = S_SQ_M;
            end
         end
         S_RAD_M: begin
            cmd.mul_op = MUL_RAD;
            state_in   = S_RAD_W;
         end
         S_RAD_W: begin
            cmd.wb_op = WB_RAD;
            state_in  = S_CHK;
         end
         S_CHK: begin
            bi_in = '0;
            if (!sts.far) begin
               state_in = S_FINISH;
            end else if (ground_en && sts.ground_ok) begin
               state_in = S_G_DIV;
            end else begin
               state_in = S_BOX_TEST;
            end
         end
         S_G_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_GND;
            state_in      = S_G_WAIT;
         end
         S_G_WAIT: begin
            if (sts.div_done) begin
               cmd.div_gnd = 1'b1;
               ax_in       = AXIS_X;
               which_in    = PASS_GROUND;
               state_in    = S_ALONG_M;
            end
         end
         S_ALONG_M: begin
            cmd.mul_op = MUL_ALONG;
            state_in   = S_ALONG_W;
         end
         S_ALONG_W: begin
            cmd.wb_op = WB_ALONG;
            if (ax_ff == AXIS_Z) begin
               state_in = (which_ff == PASS_BOX) ? S_B_COMMIT : S_G_COMMIT;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = S_ALONG_M;
            end
         end
         S_G_COMMIT: begin
            cmd.gnd_commit = 1'b1;
            bi_in          = '0;
            state_in       = S_BOX_TEST;
         end
         S_BOX_TEST: begin
            state_in = (bi_ff >= nb) ? S_FINISH : S_B_READ;
         end
         S_B_READ: begin
            cmd.box_init = 1'b1;
            ax_in        = AXIS_X;
            state_in     = S_B_AXIS;
         end
         S_B_AXIS: begin
            if (sts.d_zero) begin
               cmd.slab_zero = 1'b1;
               state_in      = S_B_NEXT;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_LO;
               state_in      = S_B_W1;
            end
         end
         S_B_W1: begin
            cmd.div_sel = DIV_HI;
            if (sts.div_done) begin
               cmd.div_t1    = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = S_B_W2;
            end
         end
         S_B_W2: begin
            if (sts.div_done) begin
               cmd.div_slab = 1'b1;
               state_in     = S_B_NEXT;
            end
         end
         S_B_NEXT: begin
            if (sts.miss || ax_ff == AXIS_Z) begin
               state_in = S_B_CHECK;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = S_B_AXIS;
            end
         end
         S_B_CHECK: begin
            if (sts.better) begin
               cmd.tuse_tmin = 1'b1;
               ax_in         = AXIS_X;
               which_in      = PASS_BOX;
               state_in      = S_ALONG_M;
            end else begin
               state_in = S_B_INC;
            end
         end
         S_B_COMMIT: begin
            cmd.box_commit = 1'b1;
            state_in       = S_B_INC;
         end
         S_B_INC: begin
            bi_in    = bi_ff + 1'b1;
            state_in = S_BOX_TEST;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ax_ff        <= AXIS_X;
         bi_ff        <= '0;
         which_ff     <= PASS_GROUND;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ax_ff        <= ax_in;
         bi_ff        <= bi_in;
         which_ff     <= which_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hdl/swept_sphere_box_hit.sv
// Swept sphere against ground plane and boxes; Q16.16 fixed point throughout.
// A load beat yields no result. When the sphere moves too little a query skips the ground
// and box tests; otherwise the ground test and each box in turn are tried. A result also
// waits for the previous result to be taken. One query is in work at a time. Divisions
// run on the single shared divider; reset is synchronous.
`include "assert_macros.svh"

module swept_sphere_box_hit import ssbh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ssbh_req_if.sink    req_bus,
   ssbh_rsp_if.source  rsp_bus,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0]          time_step_ff;
   logic [BOX_CNT_W-1:0] box_count_ff;
   logic                 ground_en_ff;
   cmd_type              cmd;
   sts_type              sts;
   req_type              req;
   rsp_type              rsp;

   // Control register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= TIME_STEP_RESET;
         box_count_ff <= '0;
         ground_en_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TIME_STEP: time_step_ff <= csr_wdata;
            CSR_BOX_COUNT: box_count_ff <= csr_wdata[BOX_CNT_W-1:0];
            CSR_GROUND_EN: ground_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Query beat payload.
   assign req.op     = req_bus.op;
   assign req.slot   = req_bus.slot;
   assign req.pos_x  = req_bus.pos_x;
   assign req.pos_y  = req_bus.pos_y;
   assign req.pos_z  = req_bus.pos_z;
   assign req.vel_x  = req_bus.vel_x;
   assign req.vel_y  = req_bus.vel_y;
   assign req.vel_z  = req_bus.vel_z;
   assign req.half_x = req_bus.half_x;
   assign req.half_y = req_bus.half_y;
   assign req.half_z = req_bus.half_z;
   assign req.radius = req_bus.radius;

   ssbh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.op),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .box_count (box_count_ff),
      .ground_en (ground_en_ff),
      .cmd       (cmd),
      .sts       (sts)
   );

   ssbh_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req       (req),
      .time_step (time_step_ff),
      .rsp       (rsp)
   );

   // Result beat payload.
   assign rsp_bus.hit             = rsp.hit;
   assign rsp_bus.hit_time        = rsp.hit_time;
   assign rsp_bus.point_x         = rsp.point_x;
   assign rsp_bus.point_y         = rsp.point_y;
   assign rsp_bus.point_z         = rsp.point_z;
   assign rsp_bus.normal_axis     = rsp.normal_axis;
   assign rsp_bus.normal_negative = rsp.normal_negative;

   // A query holds off further beats while it is in work.
   `ASSERT_NEXT(a_query_busy, clock, reset, req_bus.valid && req_bus.ready && req_bus.op == OP_QUERY, !req_bus.ready)
   // A miss carries an all-zero result.
   `ASSERT_IMPLIES(a_miss_zero, clock, reset, rsp_bus.valid && !rsp_bus.hit, rsp_bus.hit_time == '0 && rsp_bus.point_x == '0 && rsp_bus.point_y == '0 && rsp_bus.point_z == '0 && !rsp_bus.normal_negative)
   // A hit lies within the step and names a real axis.
   `ASSERT_IMPLIES(a_hit_range, clock, reset, rsp_bus.valid && rsp_bus.hit, rsp_bus.hit_time <= T_ONE && (rsp_bus.normal_axis == AXIS_X || rsp_bus.normal_axis == AXIS_Y || rsp_bus.normal_axis == AXIS_Z))

endmodule

### verif/tb.sv
// Self-checking testbench for swept_sphere_box_hit: box loads and sphere sweep queries.
// Depends on ssbh_pkg and the ssbh_req_if / ssbh_rsp_if interfaces of the RTL.
`timescale 1ns / 100ps

module tb;
   import ssbh_pkg::*;

   localparam int  UNIT       = 65536;
   localparam int  STALL_LIMIT = 100000;
   localparam int  DRAIN_CYCLES = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_we    = 1'b0;
   logic [1:0]  csr_index = CSR_TIME_STEP;
   logic [15:0] csr_wdata = '0;

   ssbh_req_if req_bus ();
   ssbh_rsp_if rsp_bus ();

   swept_sphere_box_hit uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // Shadow copy of the block's registers and box store.
   logic [15:0] step_q16  = TIME_STEP_RESET;
   logic [4:0]  boxes_on  = '0;
   logic        ground_on = 1'b0;
   longint box_cx[MAX_BOXES], box_cy[MAX_BOXES], box_cz[MAX_BOXES];
   longint box_hx[MAX_BOXES], box_hy[MAX_BOXES], box_hz[MAX_BOXES];

   req_type pending_beats[$];
   rsp_type contact_queue[$];
   req_type beat;
   int  send_idle_pct = 15;
   int  recv_idle_pct = 86;
   int  beats_queued = 0;
   int  beats_taken  = 0;
   int  error_count  = 0;
   int  quiet_cycles = 0;
   logic req_taken = 1'b0;

   // Division rounding toward minus infinity.
   function automatic longint floor_quot(longint n, longint d);
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      if (n >= 0) return n / d;
      return -((-n + d - 1) / d);
   endfunction

   function automatic longint mag(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // Earliest contact of the swept sphere with the ground and the enabled boxes.
   function automatic rsp_type sweep_contact(req_type q);
      longint p[3], d[3], pt[3], c[3], h[3], cp[3];
      longint r, best, tmin, tmax, lo, hi, t1, t2, tmp, num, ax, ay, az, t;
      longint unsigned sumsq, lim;
      int nb;
      logic [1:0] nax;
      logic nneg;
      bit found, miss, nonneg;
      rsp_type o;
      found = 0;
      best  = 0;
      nax   = AXIS_X;
      nneg  = 1'b0;
      pt[0] = 0; pt[1] = 0; pt[2] = 0;
      r = longint'({1'b0, q.radius});
      p[0] = longint'(q.pos_x);
      p[1] = longint'(q.pos_y);
      p[2] = longint'(q.pos_z);
      d[0] = floor_quot(longint'(q.vel_x) * longint'({1'b0, step_q16}), UNIT);
      d[1] = floor_quot(longint'(q.vel_y) * longint'({1'b0, step_q16}), UNIT);
      d[2] = floor_quot(longint'(q.vel_z) * longint'({1'b0, step_q16}), UNIT);
      sumsq = 0;
      for (int a = 0; a < 3; a++) sumsq += longint'(d[a] * d[a]);
      lim = longint'(r * r) / 4;

      if (sumsq > lim) begin
         // Ground plane at height zero.
         if (ground_on && d[1] != 0) begin
            num = -p[1];
            nonneg = (num == 0) || ((num > 0) == (d[1] > 0));
            if (nonneg && mag(num) <= mag(d[1])) begin
               t = floor_quot(num * UNIT, d[1]);
               best  = t;
               pt[0] = p[0] + floor_quot(t * d[0], UNIT);
               pt[1] = r;
               pt[2] = p[2] + floor_quot(t * d[2], UNIT);
               nax   = AXIS_Y;
               nneg  = d[1] > 0;
               found = 1;
            end
         end

         // Slab test against each box grown by the radius.
         nb = (boxes_on < MAX_BOXES) ? boxes_on : MAX_BOXES;
         for (int i = 0; i < nb; i++) begin
            c[0] = box_cx[i]; c[1] = box_cy[i]; c[2] = box_cz[i];
            h[0] = box_hx[i]; h[1] = box_hy[i]; h[2] = box_hz[i];
            tmin = 0;
            tmax = UNIT;
            miss = 0;
            for (int a = 0; a < 3 && !miss; a++) begin
               lo = c[a] - h[a] - r;
               hi = c[a] + h[a] + r;
               if (d[a] == 0) begin
                  if (p[a] < lo || p[a] > hi) miss = 1;
               end else begin
                  t1 = floor_quot((lo - p[a]) * UNIT, d[a]);
                  t2 = floor_quot((hi - p[a]) * UNIT, d[a]);
                  if (t1 > t2) begin
                     tmp = t1; t1 = t2; t2 = tmp;
                  end
                  if (t1 > tmin) tmin = t1;
                  if (t2 < tmax) tmax = t2;
                  if (tmin > tmax) miss = 1;
               end
            end
            if (!miss && (!found || tmin < best)) begin
               for (int a = 0; a < 3; a++) cp[a] = p[a] + floor_quot(tmin * d[a], UNIT);
               ax = mag(cp[0] - c[0]);
               ay = mag(cp[1] - c[1]);
               az = mag(cp[2] - c[2]);
               if (ax >= ay && ax >= az) nax = AXIS_X;
               else if (ay >= az) nax = AXIS_Y;
               else nax = AXIS_Z;
               nneg  = !((cp[nax] - c[nax]) > 0);
               best  = tmin;
               pt    = cp;
               found = 1;
            end
         end
      end

      o = '0;
      if (found) begin
         o.hit             = 1'b1;
         o.hit_time        = best[16:0];
         o.point_x         = clamp32(pt[0]);
         o.point_y         = clamp32(pt[1]);
         o.point_z         = clamp32(pt[2]);
         o.normal_axis     = nax;
         o.normal_negative = nneg;
      end
      return o;
   endfunction

   // Driver: a new beat goes out at the falling edge once the last one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (!req_bus.valid || req_taken) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               beat = pending_beats.pop_front();
               req_bus.op     <= beat.op;
               req_bus.slot   <= beat.slot;
               req_bus.pos_x  <= beat.pos_x;
               req_bus.pos_y  <= beat.pos_y;
               req_bus.pos_z  <= beat.pos_z;
               req_bus.vel_x  <= beat.vel_x;
               req_bus.vel_y  <= beat.vel_y;
               req_bus.vel_z  <= beat.vel_z;
               req_bus.half_x <= beat.half_x;
               req_bus.half_y <= beat.half_y;
               req_bus.half_z <= beat.half_z;
               req_bus.radius <= beat.radius;
               req_bus.valid  <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      req_bus.op = OP_LOAD;
      req_bus.slot = '0;
      req_bus.pos_x = '0; req_bus.pos_y = '0; req_bus.pos_z = '0;
      req_bus.vel_x = '0; req_bus.vel_y = '0; req_bus.vel_z = '0;
      req_bus.half_x = '0; req_bus.half_y = '0; req_bus.half_z = '0;
      req_bus.radius = '0;
   end

   // Monitor: accepted requests update the prediction, accepted results are checked.
   always @(posedge clock) begin
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         beats_taken++;
         if (req_bus.op == OP_LOAD) begin
            box_cx[req_bus.slot] = longint'(req_bus.pos_x);
            box_cy[req_bus.slot] = longint'(req_bus.pos_y);
            box_cz[req_bus.slot] = longint'(req_bus.pos_z);
            box_hx[req_bus.slot] = longint'({1'b0, req_bus.half_x});
            box_hy[req_bus.slot] = longint'({1'b0, req_bus.half_y});
            box_hz[req_bus.slot] = longint'({1'b0, req_bus.half_z});
         end else begin
            contact_queue = {contact_queue, sweep_contact('{op: req_bus.op,
               slot: req_bus.slot,
               pos_x: req_bus.pos_x, pos_y: req_bus.pos_y, pos_z: req_bus.pos_z,
               vel_x: req_bus.vel_x, vel_y: req_bus.vel_y, vel_z: req_bus.vel_z,
               half_x: req_bus.half_x, half_y: req_bus.half_y,
               half_z: req_bus.half_z, radius: req_bus.radius})};
         end
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (contact_queue.size() == 0) begin
            $error("result beat with no query outstanding");
            error_count++;
         end else begin
            rsp_type e;
            e = contact_queue.pop_front();
            if (rsp_bus.hit !== e.hit) begin
               $error("hit: expected %0d, got %0d", e.hit, rsp_bus.hit);
               error_count++;
            end
            if (rsp_bus.hit_time !== e.hit_time) begin
               $error("hit_time: expected %0d, got %0d", e.hit_time, rsp_bus.hit_time);
               error_count++;
            end
            if (rsp_bus.point_x !== e.point_x) begin
               $error("point_x: expected %0d, got %0d", e.point_x, rsp_bus.point_x);
               error_count++;
            end
            if (rsp_bus.point_y !== e.point_y) begin
               $error("point_y: expected %0d, got %0d", e.point_y, rsp_bus.point_y);
               error_count++;
            end
            if (rsp_bus.point_z !== e.point_z) begin
               $error("point_z: expected %0d, got %0d", e.point_z, rsp_bus.point_z);
               error_count++;
            end
            if (rsp_bus.normal_axis !== e.normal_axis) begin
               $error("normal_axis: expected %0d, got %0d", e.normal_axis,
                      rsp_bus.normal_axis);
               error_count++;
            end
            if (rsp_bus.normal_negative !== e.normal_negative) begin
               $error("normal_negative: expected %0d, got %0d", e.normal_negative,
                      rsp_bus.normal_negative);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_TIME_STEP: step_q16  = value;
         CSR_BOX_COUNT: boxes_on  = value[4:0];
         CSR_GROUND_EN: ground_on = value[0];
         default: ;
      endcase
   endtask

   task automatic push_load(int s, logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [30:0] hx, logic [30:0] hy, logic [30:0] hz);
      req_type b;
      b = '0;
      b.op = OP_LOAD;
      b.slot = 4'(s);
      b.pos_x = cx; b.pos_y = cy; b.pos_z = cz;
      b.half_x = hx; b.half_y = hy; b.half_z = hz;
      b.vel_x = $urandom; b.vel_y = $urandom; b.vel_z = $urandom;
      b.radius = 31'($urandom);
      pending_beats = {pending_beats, b};
      beats_queued++;
   endtask

   task automatic push_query(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                             logic [30:0] r);
      req_type b;
      b = '0;
      b.op = OP_QUERY;
      b.slot = 4'($urandom);
      b.pos_x = px; b.pos_y = py; b.pos_z = pz;
      b.vel_x = vx; b.vel_y = vy; b.vel_z = vz;
      b.half_x = 31'($urandom); b.half_y = 31'($urandom); b.half_z = 31'($urandom);
      b.radius = r;
      pending_beats = {pending_beats, b};
      beats_queued++;
   endtask

   // Signed Q16.16 value within +-lim units; now and then any 32-bit pattern.
   function automatic logic [31:0] rand_coord(int lim);
      if ($urandom_range(7) == 0) return $urandom;
      return int'($urandom_range(0, 2 * lim * UNIT)) - lim * UNIT;
   endfunction

   function automatic logic [30:0] rand_extent(int lim);
      if ($urandom_range(7) == 0) return 31'($urandom);
      return 31'($urandom_range(0, lim * UNIT));
   endfunction

   // Wait until every beat was taken and every result arrived, then let loads settle.
   task automatic wait_idle();
      while (beats_taken != beats_queued || contact_queue.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Mostly sweeps near the boxes, with box reloads mixed in.
   task automatic random_phase(int n, int vel_lim);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(4) == 0)
            push_load($urandom_range(15), rand_coord(40), rand_coord(20), rand_coord(40),
                      rand_extent(4), rand_extent(4), rand_extent(4));
         else
            push_query(rand_coord(40), rand_coord(20), rand_coord(40),
                       rand_coord(vel_lim), rand_coord(vel_lim), rand_coord(vel_lim),
                       rand_extent(3));
      end
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      req_bus.valid = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: every slot loaded, then the corner cases of a sweep.
      csr_write(CSR_TIME_STEP, TIME_STEP_RESET);
      csr_write(CSR_BOX_COUNT, 16'(MAX_BOXES));
      csr_write(CSR_GROUND_EN, 16'd1);
      for (int s = 0; s < 14; s++)
         push_load(s, (s * 10 - 60) * UNIT, 5 * UNIT, ((s % 4) * 8 - 12) * UNIT,
                   31'((1 + s % 3) * UNIT), 31'(UNIT), 31'(2 * UNIT));
      push_load(14, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0, '0);
      push_load(15, 0, 40 * UNIT, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      // No motion, and a motion that rounds to zero or to minus one.
      push_query(0, 2 * UNIT, 0, 0, 0, 0, 31'(UNIT));
      push_query(0, 2 * UNIT, 0, 1, 0, 0, 31'd0);
      push_query(0, 2 * UNIT, 0, -1, 0, 0, 31'd0);
      // Ground hit falling down and rising up through the plane.
      push_query(100 * UNIT, 2 * UNIT, 0, 0, -200 * UNIT, 0, 31'(UNIT / 2));
      push_query(100 * UNIT, -UNIT, 0, 50 * UNIT, 200 * UNIT, 0, 31'(UNIT / 2));
      // Start inside box 0, and a sweep along x through the row of boxes.
      push_query(-60 * UNIT, 5 * UNIT, -12 * UNIT, 100 * UNIT, 0, 0, 31'(UNIT));
      push_query(-80 * UNIT, 5 * UNIT, -12 * UNIT, 2000 * UNIT, 0, 0, 31'(UNIT / 4));
      // Extreme positions, velocities and radii.
      push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
      push_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd0);
      push_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
      wait_idle();

      // Long step, box count past the store size, no ground.
      send_idle_pct = 15;
      recv_idle_pct = 86;
      csr_write(CSR_TIME_STEP, 16'hFFFF);
      csr_write(CSR_BOX_COUNT, 16'd31);
      csr_write(CSR_GROUND_EN, 16'd0);
      random_phase(50, 60);
      wait_idle();

      send_idle_pct = 86;
      recv_idle_pct = 15;
      csr_write(CSR_TIME_STEP, TIME_STEP_RESET);
      csr_write(CSR_BOX_COUNT, 16'(MAX_BOXES));
      csr_write(CSR_GROUND_EN, 16'd1);
      random_phase(50, 3000);
      wait_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      csr_write(CSR_TIME_STEP, 16'd4000);
      csr_write(CSR_BOX_COUNT, 16'd5);
      random_phase(20, 800);
      wait_idle();

      // Zero step and no boxes: nothing can hit.
      csr_write(CSR_TIME_STEP, 16'd0);
      csr_write(CSR_BOX_COUNT, 16'd0);
      random_phase(10, 3000);

      while (beats_taken != beats_queued || contact_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (contact_queue.size() != 0) begin
         $error("results still outstanding at end of run");
         error_count++;
      end
      if (error_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/ssbh_pkg.sv
hdl/ssbh_if.sv
hdl/ssbh_div.sv
hdl/ssbh_dp.sv
hdl/ssbh_ctrl.sv
hdl/swept_sphere_box_hit.sv
verif/tb.sv
